// ----- rtl/core/rmbr_pkg.sv -----
// Shared types and constants for the row mask bit repacker.
// No dependencies; imported by every module under rtl/core.
package rmbr_pkg;

    localparam int WORD_BITS  = 32;
    localparam int MAX_PAGES  = 4096;
    localparam int BYTE_BITS  = 8;
    localparam int PEND_BITS  = BYTE_BITS - 1;

    localparam int PAGE_W     = 13;
    localparam int FILL_W     = 11;
    localparam int PSIZE_W    = 11;
    localparam int SLOT_W     = 17;
    localparam int SHIFT_W    = $clog2(WORD_BITS);
    localparam int BASE_W     = SLOT_W + SHIFT_W;
    localparam int PROD_W     = PAGE_W + PSIZE_W;
    localparam int KV_W       = PROD_W + 1;
    localparam int NBITS_W    = $clog2(WORD_BITS + 1);
    localparam int ACC_W      = PEND_BITS + WORD_BITS;
    localparam int TOT_W      = $clog2(ACC_W + 1);
    localparam int PCNT_W     = $clog2(BYTE_BITS);

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 1;
    localparam logic [APB_ADDR_W-1:0] ADDR_PAGE_KEYS = '0;
    localparam logic [PSIZE_W-1:0]    PAGE_KEYS_RST  = PSIZE_W'(16);

    typedef struct packed {
        logic [WORD_BITS-1:0] mask_word;
        logic                 word_present;
        logic [PAGE_W-1:0]    page_count;
        logic [FILL_W-1:0]    last_page_fill;
        logic                 row_end;
        logic                 request_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_BITS-1:0] packed_byte;
        logic                 byte_last;
    } t_out_item;

    // One classified slot: kept bits only, LSB first
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [NBITS_W-1:0]   nbits;
        logic                 req_end;
    } t_slot_entry;

endpackage

// ----- rtl/core/rmbr_front.sv -----
// Front end: accepts slot transactions, tracks the slot index and trims each
// word to the request's key length. Depends on rmbr_pkg.
module rmbr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rmbr_pkg::t_in_item            i_in_data,
    input  logic [rmbr_pkg::PSIZE_W-1:0]  i_page_keys,
    input  logic                          i_fifo_full,
    output logic                          o_push,
    output rmbr_pkg::t_slot_entry         o_entry
);
    import rmbr_pkg::*;

    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic                 r_a_valid, n_a_valid;
    logic [WORD_BITS-1:0] r_a_word;
    logic [PROD_W-1:0]    r_a_prod;
    logic                 r_a_no_pages;
    logic [FILL_W-1:0]    r_a_fill;
    logic [BASE_W-1:0]    r_a_base;
    logic                 r_a_req_end;

    logic                 accept;
    logic [PAGE_W-1:0]    pages_sat;
    logic [PAGE_W-1:0]    pages_m1;
    logic [KV_W-1:0]      kv;
    logic [KV_W-1:0]      diff;
    logic [NBITS_W-1:0]   nbits;
    logic [WORD_BITS-1:0] keep;

    assign o_in_ready = !r_a_valid || !i_fifo_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_a_valid && !i_fifo_full;

    always_comb begin
        if ({4'b0, i_in_data.page_count} > 17'(MAX_PAGES)) begin
            pages_sat = PAGE_W'(MAX_PAGES);
        end else begin
            pages_sat = i_in_data.page_count;
        end
        pages_m1 = pages_sat - PAGE_W'(1);
        n_slot   = i_in_data.row_end ? '0 : r_slot + SLOT_W'(1);
        n_a_valid = accept ? 1'b1 : (o_push ? 1'b0 : r_a_valid);
    end

    // Second half: key length, bits left in this slot, mask
    always_comb begin
        kv   = r_a_no_pages ? '0 : KV_W'(r_a_prod) + KV_W'(r_a_fill);
        diff = kv - KV_W'(r_a_base);
        if (KV_W'(r_a_base) < kv) begin
            nbits = (diff > KV_W'(WORD_BITS)) ? NBITS_W'(WORD_BITS) : diff[NBITS_W-1:0];
        end else begin
            nbits = '0;
        end
        keep = ~({WORD_BITS{1'b1}} << nbits);
        o_entry.word    = r_a_word & keep;
        o_entry.nbits   = nbits;
        o_entry.req_end = r_a_req_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            if (accept) begin
                r_slot <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_word     <= i_in_data.word_present ? i_in_data.mask_word : '0;
            r_a_prod     <= PROD_W'(pages_m1) * PROD_W'(i_page_keys);
            r_a_no_pages <= (i_in_data.page_count == '0);
            r_a_fill     <= i_in_data.last_page_fill;
            r_a_base     <= {r_slot, {SHIFT_W{1'b0}}};
            r_a_req_end  <= i_in_data.row_end && i_in_data.request_end;
        end
    end

endmodule

// ----- rtl/core/rmbr_fifo.sv -----
// Short queue of classified slots between front and back end.
// Depends on rmbr_pkg.
module rmbr_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rmbr_pkg::t_slot_entry i_entry,
    input  logic                  i_pop,
    output rmbr_pkg::t_slot_entry o_entry,
    output logic                  o_full,
    output logic                  o_empty
);
    import rmbr_pkg::*;

    t_slot_entry       r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr, r_rd;
    logic [FCNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + FCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - FCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + FPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FCNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

// ----- rtl/core/rmbr_back.sv -----
// Back end: concatenates kept bits and emits one byte per cycle, while the output
// is not held, into the output register. Depends on rmbr_pkg.
module rmbr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_entry_valid,
    input  rmbr_pkg::t_slot_entry i_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rmbr_pkg::t_out_item   o_out_data
);
    import rmbr_pkg::*;

    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [TOT_W-1:0]     r_total, n_total;
    logic                 r_req_end, n_req_end;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 out_free;
    logic                 emit;
    logic                 advance;
    logic [BYTE_BITS-1:0] byte_val;
    logic                 byte_last;
    logic [ACC_W-1:0]     lacc;
    logic [TOT_W-1:0]     ltot;
    logic                 lreq;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        byte_val  = r_acc[BYTE_BITS-1:0];
        byte_last = 1'b0;
        if (r_total >= TOT_W'(BYTE_BITS)) begin
            emit      = 1'b1;
            byte_last = r_req_end && (r_total == TOT_W'(BYTE_BITS));
            lacc      = r_acc >> BYTE_BITS;
            ltot      = r_total - TOT_W'(BYTE_BITS);
            lreq      = r_req_end && (r_total != TOT_W'(BYTE_BITS));
        end else if (r_req_end && (r_total != '0)) begin
            // request closes on a partial byte, upper bits already zero
            emit      = 1'b1;
            byte_last = 1'b1;
            lacc      = '0;
            ltot      = '0;
            lreq      = 1'b0;
        end else begin
            emit      = 1'b0;
            lacc      = r_acc;
            ltot      = r_total;
            lreq      = 1'b0;
        end

        advance = !emit || out_free;
        o_pop   = advance && i_entry_valid && (ltot < TOT_W'(BYTE_BITS)) && !lreq;

        n_acc     = r_acc;
        n_total   = r_total;
        n_req_end = r_req_end;
        if (o_pop) begin
            n_acc     = lacc | (ACC_W'(i_entry.word) << ltot[PCNT_W-1:0]);
            n_total   = ltot + TOT_W'(i_entry.nbits);
            n_req_end = i_entry.req_end;
        end else if (advance) begin
            n_acc     = lacc;
            n_total   = ltot;
            n_req_end = lreq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_total     <= '0;
            r_req_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_total   <= n_total;
            r_req_end <= n_req_end;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_out.packed_byte <= byte_val;
            r_out.byte_last   <= byte_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOT_W'(ACC_W))
        else $error("bit count beyond accumulator");
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc >> r_total) == '0)
        else $error("stray bits above bit count");
    a_pop_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (ltot < TOT_W'(BYTE_BITS)) && !lreq)
        else $error("slot taken before bytes drained");

endmodule

// ----- rtl/core/row_mask_bit_repacker_core.sv -----
// Top level of the row mask bit repacker: APB register, front end, slot
// queue and byte back end. Depends on rmbr_pkg, rmbr_front, rmbr_fifo, rmbr_back.
//
//  channel  direction  handshake                    payload
//  in       input      i_in_valid / o_in_ready      t_in_item (one mask word slot)
//  out      output     o_out_valid / i_out_ready    t_out_item (one packed byte)
//  apb      input      psel/penable/pwrite/pready   keys per page at byte address 0
//
// Throughput: the back end emits one byte per cycle while the output is not held;
// a slot keeping 32 bits gives four bytes, and a request closing on a partial
// byte adds a zero-padded closing byte, as set by the byte-wide output register.
// Input passes the front register, slot queue, accumulator and output register.
// Reset: synchronous, active low; keys per page returns to 16, queue and counters clear.
// Stalls: the four-entry queue lets the front keep taking slots while the
// output is held; the front stalls only when the queue is full.
module row_mask_bit_repacker_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slot input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rmbr_pkg::t_in_item                   i_in_data,
    // byte output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rmbr_pkg::t_out_item                  o_out_data,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rmbr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rmbr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rmbr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import rmbr_pkg::*;

    logic [PSIZE_W-1:0] r_page_keys;
    logic               cfg_wr;

    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    t_slot_entry        front_entry;
    t_slot_entry        back_entry;

    // Register file: single register, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_keys <= PAGE_KEYS_RST;
        end else if (cfg_wr && (paddr == ADDR_PAGE_KEYS)) begin
            r_page_keys <= pwdata[PSIZE_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_PAGE_KEYS) ? APB_DATA_W'(r_page_keys) : '0;

    // Front: slot index, key length, trim
    rmbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_page_keys (r_page_keys),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    // Decoupling queue
    rmbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (back_entry),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    // Back: bit concatenation and byte emission
    rmbr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (!fifo_empty),
        .i_entry       (back_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule
